### rtl/itp_pkg.sv
// ============================================================================
// itp_pkg
// Shared types, sizes and character classification for the infix-to-postfix
// converter.
// ============================================================================
`default_nettype none

package itp_pkg;

    // Depth of the operator stack and the widths that follow from it.
    localparam int STACK_DEPTH = 32;
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int STK_CW      = $clog2(STACK_DEPTH + 1);

    // Error codes carried by a result beat.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_UNEXPECT  = 3'd1;
    localparam logic [2:0] ERR_CLOSE     = 3'd2;
    localparam logic [2:0] ERR_OPEN      = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

    // Bracket kinds.
    localparam logic [1:0] KIND_PAREN   = 2'd0;
    localparam logic [1:0] KIND_SQUARE  = 2'd1;
    localparam logic [1:0] KIND_CURLY   = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    // Precedence levels; PREC_NONE marks a byte that is no operator.
    localparam logic [2:0] PREC_CLOSE = 3'd0;
    localparam logic [2:0] PREC_OPEN  = 3'd1;
    localparam logic [2:0] PREC_ADD   = 3'd2;
    localparam logic [2:0] PREC_MUL   = 3'd3;
    localparam logic [2:0] PREC_MOD   = 3'd4;
    localparam logic [2:0] PREC_NONE  = 3'd7;

    // One result item.
    typedef struct packed {
        logic [7:0] token;
        logic       has_token;
        logic [2:0] err;
        logic       last;
    } t_res;

    // Control from the sequencer to the output queue.
    typedef struct packed {
        logic emit;   // a new result is written into the hold slot
        logic fin;    // its last flag is already final
        logic seal;   // mark the held result as the last of the expression
    } t_oq_ctl;

    function automatic logic f_is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic f_is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic f_is_open(input logic [7:0] c);
        return (c == 8'h28) || (c == 8'h5B) || (c == 8'h7B);
    endfunction

    function automatic logic f_is_close(input logic [7:0] c);
        return (c == 8'h29) || (c == 8'h5D) || (c == 8'h7D);
    endfunction

    function automatic logic [2:0] f_prec(input logic [7:0] c);
        logic [2:0] p;
        case (c)
            8'h7D, 8'h29, 8'h5D: p = PREC_CLOSE;
            8'h7B, 8'h28, 8'h5B: p = PREC_OPEN;
            8'h2B, 8'h2D:        p = PREC_ADD;
            8'h2A, 8'h2F:        p = PREC_MUL;
            8'h25:               p = PREC_MOD;
            default:             p = PREC_NONE;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] f_kind(input logic [7:0] c);
        logic [1:0] k;
        case (c)
            8'h28, 8'h29: k = KIND_PAREN;
            8'h5B, 8'h5D: k = KIND_SQUARE;
            8'h7B, 8'h7D: k = KIND_CURLY;
            default:      k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

### rtl/itp_ram.sv
// ============================================================================
// itp_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ============================================================================
`default_nettype none

module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/itp_outq.sv
// ============================================================================
// itp_outq
// Hold slot and output register for result beats.
// ============================================================================
`default_nettype none

module itp_outq
    import itp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_oq_ctl i_ctl,
    input  wire t_res    i_res,
    output logic         o_go,
    output logic         o_valid,
    output t_res         o_res,
    input  wire logic    i_ready
);

    logic r_hold_v;
    logic r_hold_fin;
    t_res r_hold;
    logic r_out_v;
    t_res r_out;
    logic out_free;
    logic mv;

    // The hold slot keeps the newest result until its last flag is known:
    // a later result or the end of the expression settles it.
    assign out_free = !r_out_v || i_ready;
    assign o_go     = !r_hold_v || out_free;
    assign mv       = r_hold_v && out_free && (r_hold_fin || i_ctl.emit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_ctl.emit) begin
                r_hold_v <= 1'b1;
            end else if (mv) begin
                r_hold_v <= 1'b0;
            end
            if (mv) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
        if (i_ctl.emit) begin
            r_hold     <= i_res;
            r_hold_fin <= i_ctl.fin;
        end else if (i_ctl.seal) begin
            r_hold.last <= 1'b1;
            r_hold_fin  <= 1'b1;
        end
        if (mv) begin
            r_out <= r_hold;
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;

endmodule

`default_nettype wire

### rtl/itp_ctrl.sv
// ============================================================================
// itp_ctrl
// Shunting-yard sequencer: classifies a character, pushes and pops the
// operator stack held in RAM, and produces result beats.
// ============================================================================
`default_nettype none

module itp_ctrl
    import itp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_char,
    input  wire logic              i_last,
    input  wire logic              i_go,
    output t_oq_ctl                o_ctl,
    output t_res                   o_res,
    output logic                   o_we,
    output logic [STK_AW-1:0]      o_waddr,
    output logic [7:0]             o_wdata,
    output logic [STK_AW-1:0]      o_raddr,
    input  wire logic [7:0]        i_rdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_OP, ST_FLUSH} t_state;

    t_state            r_state, n_state;
    logic [7:0]        r_char, n_char;
    logic              r_last, n_last;
    logic [STK_CW-1:0] r_cnt, n_cnt;
    logic              r_disc, n_disc;
    logic              r_any, n_any;
    logic              r_fwd, n_fwd;
    logic [7:0]        r_fwd_data;

    logic [7:0]        top;
    logic              empty;
    logic              full;
    logic [STK_CW-1:0] rd_ptr;
    t_state            after_op;

    // A push writes the entry that is read in the same cycle; the RAM then
    // returns the old word, so the pushed byte is forwarded for one cycle.
    assign top    = r_fwd ? r_fwd_data : i_rdata;
    assign empty  = (r_cnt == '0);
    assign full   = (r_cnt == STK_CW'(STACK_DEPTH));
    assign rd_ptr = n_cnt - STK_CW'(1);
    assign after_op = r_last ? ST_FLUSH : ST_IDLE;

    assign o_ready = (r_state == ST_IDLE);
    assign o_raddr = rd_ptr[STK_AW-1:0];
    assign o_waddr = r_cnt[STK_AW-1:0];
    assign o_wdata = r_char;

    always_comb begin
        n_state    = r_state;
        n_char     = r_char;
        n_last     = r_last;
        n_cnt      = r_cnt;
        n_disc     = r_disc;
        n_any      = r_any;
        o_we       = 1'b0;
        o_ctl      = '0;
        o_res      = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (r_disc) begin
                        n_disc = !i_last;
                    end else begin
                        n_char  = i_char;
                        n_last  = i_last;
                        n_any   = 1'b0;
                        n_state = ST_OP;
                    end
                end
            end
            ST_OP: begin
                if (i_go) begin
                    if (f_is_alnum(r_char)) begin
                        o_ctl.emit      = 1'b1;
                        o_res.token     = r_char;
                        o_res.has_token = 1'b1;
                        n_state         = after_op;
                    end else if (f_is_ws(r_char)) begin
                        n_state = after_op;
                    end else if (f_prec(r_char) == PREC_NONE) begin
                        o_ctl.emit = 1'b1;
                        o_res.err  = ERR_UNEXPECT;
                        o_res.last = 1'b1;
                        n_cnt      = '0;
                        n_disc     = !r_last;
                        n_state    = ST_IDLE;
                    end else if (!empty && !f_is_open(r_char) && !f_is_open(top) &&
                                 f_prec(r_char) <= f_prec(top)) begin
                        // Pop one operator of equal or higher precedence.
                        o_ctl.emit      = 1'b1;
                        o_res.token     = top;
                        o_res.has_token = 1'b1;
                        n_cnt           = r_cnt - STK_CW'(1);
                    end else if (f_is_close(r_char)) begin
                        if (!empty && f_is_open(top) && f_kind(top) == f_kind(r_char)) begin
                            n_cnt   = r_cnt - STK_CW'(1);
                            n_state = after_op;
                        end else begin
                            o_ctl.emit = 1'b1;
                            o_res.err  = ERR_CLOSE;
                            o_res.last = 1'b1;
                            n_cnt      = '0;
                            n_disc     = !r_last;
                            n_state    = ST_IDLE;
                        end
                    end else if (full) begin
                        o_ctl.emit = 1'b1;
                        o_res.err  = ERR_OVERFLOW;
                        o_res.last = 1'b1;
                        n_cnt      = '0;
                        n_disc     = !r_last;
                        n_state    = ST_IDLE;
                    end else begin
                        o_we    = 1'b1;
                        n_cnt   = r_cnt + STK_CW'(1);
                        n_state = after_op;
                    end
                end
            end
            ST_FLUSH: begin
                if (i_go) begin
                    if (empty) begin
                        if (r_any) begin
                            o_ctl.seal = 1'b1;
                        end else begin
                            o_ctl.emit = 1'b1;
                            o_res.last = 1'b1;
                        end
                        n_state = ST_IDLE;
                    end else if (f_is_open(top)) begin
                        o_ctl.emit = 1'b1;
                        o_res.err  = ERR_OPEN;
                        o_res.last = 1'b1;
                        n_cnt      = '0;
                        n_state    = ST_IDLE;
                    end else begin
                        o_ctl.emit      = 1'b1;
                        o_res.token     = top;
                        o_res.has_token = 1'b1;
                        n_cnt           = r_cnt - STK_CW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        o_ctl.fin = o_res.last || !r_last;
        if (r_state != ST_IDLE) begin
            n_any = r_any || o_ctl.emit;
        end
        n_fwd = o_we;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_disc  <= 1'b0;
            r_any   <= 1'b0;
            r_fwd   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_disc  <= n_disc;
            r_any   <= n_any;
            r_fwd   <= n_fwd;
            r_last  <= n_last;
        end
        r_char     <= n_char;
        r_fwd_data <= r_char;
    end

endmodule

`default_nettype wire

### rtl/infix_to_postfix_converter_core.sv
// ============================================================================
// infix_to_postfix_converter_core
// Streaming shunting-yard converter from infix characters to postfix tokens.
// ============================================================================
//
// The slave channel takes one ASCII character per beat in s_axis_tdata, with
// s_axis_tlast marking the final character of an expression. The master
// channel returns one result per beat: the token byte and an error code in
// m_axis_tdata, the has-token flag in m_axis_tuser, and m_axis_tlast on the
// final result of the expression. Separators between tokens are left to the
// receiver.
//
// An accepted character is taken in the idle state and handled in the
// operator state, which also pops, one at a time, each operator that the
// character displaces. A final character then moves to the flush state,
// which pops the remaining operators one at a time and closes the
// expression. A new character is accepted only in the idle state. The stack
// RAM is read once per cycle with registered read data, so pops proceed one
// per cycle while the output queue can take results. The newest result waits
// in a hold slot, before the output register, until its last flag is known.
//
// Reset empties the stack, clears the error-discard mode and drops any
// result in flight; the stack RAM itself is not cleared, as only entries
// below the stack count are ever used. When the receiver stalls, the hold
// slot and output register fill and the sequencer pauses, so input beats
// back up without any result being lost.
//
`default_nettype none

module infix_to_postfix_converter_core
    import itp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] char_in
    input  wire logic        i_s_axis_tlast,   // last_in
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [7:0] token_out, [10:8] error_code,
                                               // [15:11] zero
    output logic             o_m_axis_tuser,   // [0] has_token
    output logic             o_m_axis_tlast    // last_out
);

    t_oq_ctl           ctl;
    t_res              res;
    t_res              out_res;
    logic              go;
    logic              we;
    logic [STK_AW-1:0] waddr;
    logic [STK_AW-1:0] raddr;
    logic [7:0]        wdata;
    logic [7:0]        rdata;

    // The sequencer owns the stack pointer and all stack traffic.
    itp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_char  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_go    (go),
        .o_ctl   (ctl),
        .o_res   (res),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

    // Operator stack storage.
    itp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Hold slot plus output register; decouples the master side stalls.
    itp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_res   (res),
        .o_go    (go),
        .o_valid (o_m_axis_tvalid),
        .o_res   (out_res),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {5'b00000, out_res.err, out_res.token};
    assign o_m_axis_tuser = out_res.has_token;
    assign o_m_axis_tlast = out_res.last;

    // A result is only produced when the hold slot can take it.
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.emit |-> go)
        else $error("result produced while the hold slot is blocked");

    // Sealing and producing a new result never coincide.
    a_seal_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctl.emit && ctl.seal))
        else $error("seal and emit in the same cycle");

    // Token results carry no error and are never marked last when made.
    a_token_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.emit && res.has_token) |-> (res.err == ERR_NONE && !res.last))
        else $error("token result with error or early last flag");

    // A beat without a token is an end marker or an error and ends the run.
    a_notoken_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("tokenless result beat without last");

endmodule

`default_nettype wire
